[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[hdl/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// shared constants, codes and types of the midpoint ellipse rasterizer
// ----------------------------------------------------------------------------
package mer_pkg;

    // default geometry
    localparam int AXIS_BITS_DEF  = 10;
    localparam int COORD_BITS_DEF = 12;

    // request queue between front and engine, power of two
    localparam int QUEUE_DEPTH = 2;

    // command codes on the input channel
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // request kinds as classified by the front
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_kind_t;

    // quadrant codes of the mirrored pixels
    localparam logic [1:0] QUAD_PP = 2'd0;  // +x, +y
    localparam logic [1:0] QUAD_PN = 2'd1;  // +x, -y
    localparam logic [1:0] QUAD_NN = 2'd2;  // -x, -y
    localparam logic [1:0] QUAD_NP = 2'd3;  // -x, +y

    // point hand-off from engine to pixel emitter
    typedef struct packed {
        logic valid;
        logic done;
    } pt_ctrl_t;

    // engine sequencer states
    typedef enum logic [4:0] {
        ENG_IDLE,
        ENG_ST_ASQ,
        ENG_ST_BSQ,
        ENG_ST_ASQB,
        ENG_ST_DINIT,
        ENG_R1_LHS,
        ENG_R1_RHS,
        ENG_R1_CMP,
        ENG_R1_INC,
        ENG_R1_DEC,
        ENG_R1_UPD,
        ENG_R2_TX,
        ENG_R2_TY,
        ENG_R2_BTX,
        ENG_R2_ATY,
        ENG_R2_AB,
        ENG_R2_SUB,
        ENG_R2_CHK,
        ENG_R2_XT,
        ENG_R2_MIX,
        ENG_R2_UPD,
        ENG_EMIT
    } eng_state_t;

endpackage

[hdl/mer_front.sv]
// ----------------------------------------------------------------------------
// mer_front
// accepts input requests, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module mer_front #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic        [AXIS_BITS-1:0]  semi_axis_a,
    input  logic        [AXIS_BITS-1:0]  semi_axis_b,
    output logic                         q_valid,
    input  logic                         q_pop,
    output mer_pkg::req_kind_t           q_kind,
    output logic signed [COORD_BITS-1:0] q_cx,
    output logic signed [COORD_BITS-1:0] q_cy,
    output logic        [AXIS_BITS-1:0]  q_a,
    output logic        [AXIS_BITS-1:0]  q_b
);

    localparam int PTR_W = (mer_pkg::QUEUE_DEPTH > 1) ? $clog2(mer_pkg::QUEUE_DEPTH) : 1;
    localparam int ENT_W = 1 + 2 * COORD_BITS + 2 * AXIS_BITS;

    logic [ENT_W-1:0] q_mem [mer_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    mer_pkg::req_kind_t kind_in;
    logic [ENT_W-1:0]   entry_in;
    logic [ENT_W-1:0]   entry_out;
    logic               push;

    // classify the command
    assign kind_in  = (cmd == mer_pkg::CMD_STEP) ? mer_pkg::REQ_STEP : mer_pkg::REQ_START;
    assign entry_in = {kind_in, center_x, center_y, semi_axis_a, semi_axis_b};

    assign in_stall = (count_reg == (PTR_W+1)'(mer_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry_in;
        end
    end

    assign entry_out = q_mem[rd_ptr_reg];
    assign q_kind    = mer_pkg::req_kind_t'(entry_out[ENT_W-1]);
    assign q_cx      = entry_out[ENT_W-2 -: COORD_BITS];
    assign q_cy      = entry_out[ENT_W-2-COORD_BITS -: COORD_BITS];
    assign q_a       = entry_out[2*AXIS_BITS-1 -: AXIS_BITS];
    assign q_b       = entry_out[AXIS_BITS-1:0];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/mer_engine.sv]
// ----------------------------------------------------------------------------
// mer_engine
// midpoint decision sequencer around one shared multiplier
// ----------------------------------------------------------------------------
module mer_engine #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  mer_pkg::req_kind_t           q_kind,
    input  logic signed [COORD_BITS-1:0] q_cx,
    input  logic signed [COORD_BITS-1:0] q_cy,
    input  logic        [AXIS_BITS-1:0]  q_a,
    input  logic        [AXIS_BITS-1:0]  q_b,
    output mer_pkg::pt_ctrl_t            pt_ctrl,
    input  logic                         pt_ready,
    output logic signed [COORD_BITS-1:0] pt_org_x,
    output logic signed [COORD_BITS-1:0] pt_org_y,
    output logic        [AXIS_BITS-1:0]  pt_x,
    output logic        [AXIS_BITS-1:0]  pt_y
);

    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int MA_W  = 2 * AXIS_BITS;
    localparam int MB_W  = 2 * AXIS_BITS + 2;
    localparam int MP_W  = MA_W + MB_W;
    localparam int DEC_W = 4 * AXIS_BITS + 8;

    mer_pkg::eng_state_t state_reg, state_next;

    logic                         active_reg, active_next;
    logic                         region2_reg, region2_next;
    logic        [AXIS_BITS-1:0]  x_reg, x_next;
    logic        [AXIS_BITS-1:0]  y_reg, y_next;
    logic        [AXIS_BITS-1:0]  a_in_reg, a_in_next;
    logic        [AXIS_BITS-1:0]  b_in_reg, b_in_next;
    logic signed [COORD_BITS-1:0] org_x_reg, org_x_next;
    logic signed [COORD_BITS-1:0] org_y_reg, org_y_next;
    logic        [SQ_W-1:0]       a_sq_reg, a_sq_next;
    logic        [SQ_W-1:0]       b_sq_reg, b_sq_next;
    logic        [DEC_W-1:0]      dec_reg, dec_next;
    logic        [DEC_W-1:0]      t0_reg, t0_next;
    logic        [DEC_W-1:0]      t1_reg, t1_next;
    logic        [DEC_W-1:0]      t2_reg, t2_next;

    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [MP_W-1:0]      mul_p;
    logic [DEC_W-1:0]     mul_ext;
    logic [DEC_W-1:0]     a_sq_ext;
    logic [DEC_W-1:0]     b_sq_ext;
    logic [AXIS_BITS:0]   x_inc;
    logic [AXIS_BITS:0]   y_dbl_m1;
    logic [AXIS_BITS:0]   tx;
    logic [AXIS_BITS-1:0] ty;
    logic [AXIS_BITS+1:0] x_dbl_p3;
    logic                 dec_neg;

    assign x_inc    = {1'b0, x_reg} + (AXIS_BITS+1)'(1);
    assign y_dbl_m1 = {y_reg, 1'b0} - (AXIS_BITS+1)'(1);
    assign tx       = {x_reg, 1'b1};
    assign ty       = (y_reg != '0) ? (y_reg - AXIS_BITS'(1)) : AXIS_BITS'(1);
    assign x_dbl_p3 = {1'b0, x_reg, 1'b0} + (AXIS_BITS+2)'(3);
    assign a_sq_ext = DEC_W'(a_sq_reg);
    assign b_sq_ext = DEC_W'(b_sq_reg);
    assign dec_neg  = dec_reg[DEC_W-1];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            mer_pkg::ENG_ST_ASQ:
            begin
                mul_a = MA_W'(a_in_reg);
                mul_b = MB_W'(a_in_reg);
            end
            mer_pkg::ENG_ST_BSQ:
            begin
                mul_a = MA_W'(b_in_reg);
                mul_b = MB_W'(b_in_reg);
            end
            mer_pkg::ENG_ST_ASQB:
            begin
                mul_a = a_sq_reg;
                mul_b = MB_W'(b_in_reg);
            end
            mer_pkg::ENG_R1_LHS, mer_pkg::ENG_R2_XT:
            begin
                mul_a = b_sq_reg;
                mul_b = MB_W'(x_inc);
            end
            mer_pkg::ENG_R1_RHS:
            begin
                mul_a = a_sq_reg;
                mul_b = MB_W'(y_dbl_m1);
            end
            mer_pkg::ENG_R1_INC:
            begin
                mul_a = b_sq_reg;
                mul_b = MB_W'(x_dbl_p3);
            end
            mer_pkg::ENG_R1_DEC:
            begin
                mul_a = a_sq_reg;
                mul_b = MB_W'(y_reg - AXIS_BITS'(1));
            end
            mer_pkg::ENG_R2_TX:
            begin
                mul_a = MA_W'(tx);
                mul_b = MB_W'(tx);
            end
            mer_pkg::ENG_R2_TY:
            begin
                mul_a = MA_W'(ty);
                mul_b = MB_W'(ty);
            end
            mer_pkg::ENG_R2_BTX:
            begin
                mul_a = b_sq_reg;
                mul_b = t0_reg[MB_W-1:0];
            end
            mer_pkg::ENG_R2_ATY:
            begin
                mul_a = a_sq_reg;
                mul_b = t1_reg[MB_W-1:0];
            end
            mer_pkg::ENG_R2_AB:
            begin
                mul_a = a_sq_reg;
                mul_b = MB_W'(b_sq_reg);
            end
            mer_pkg::ENG_R2_CHK:
            begin
                mul_a = a_sq_reg;
                mul_b = MB_W'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_ext = DEC_W'(mul_p);

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        region2_next = region2_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        a_in_next    = a_in_reg;
        b_in_next    = b_in_reg;
        org_x_next   = org_x_reg;
        org_y_next   = org_y_reg;
        a_sq_next    = a_sq_reg;
        b_sq_next    = b_sq_reg;
        dec_next     = dec_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        q_pop        = 1'b0;
        pt_ctrl      = '0;

        unique case (state_reg)
            mer_pkg::ENG_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_kind == mer_pkg::REQ_START)
                    begin
                        org_x_next = q_cx;
                        org_y_next = q_cy;
                        a_in_next  = q_a;
                        b_in_next  = q_b;
                        state_next = mer_pkg::ENG_ST_ASQ;
                    end
                    else if (!active_reg)
                    begin
                        state_next = mer_pkg::ENG_IDLE;
                    end
                    else if (region2_reg)
                    begin
                        state_next = mer_pkg::ENG_R2_CHK;
                    end
                    else
                    begin
                        state_next = mer_pkg::ENG_R1_LHS;
                    end
                end
            end
            // start: squares and the region-1 initial term
            mer_pkg::ENG_ST_ASQ:
            begin
                a_sq_next    = mul_p[SQ_W-1:0];
                x_next       = '0;
                y_next       = b_in_reg;
                region2_next = 1'b0;
                active_next  = 1'b1;
                state_next   = mer_pkg::ENG_ST_BSQ;
            end
            mer_pkg::ENG_ST_BSQ:
            begin
                b_sq_next  = mul_p[SQ_W-1:0];
                state_next = mer_pkg::ENG_ST_ASQB;
            end
            mer_pkg::ENG_ST_ASQB:
            begin
                t0_next    = mul_ext;
                state_next = mer_pkg::ENG_ST_DINIT;
            end
            mer_pkg::ENG_ST_DINIT:
            begin
                dec_next   = (b_sq_ext << 2) + a_sq_ext - (t0_reg << 2);
                state_next = mer_pkg::ENG_EMIT;
            end
            // region 1 test and step
            mer_pkg::ENG_R1_LHS:
            begin
                if (y_reg == '0)
                begin
                    region2_next = 1'b1;
                    state_next   = mer_pkg::ENG_R2_TX;
                end
                else
                begin
                    t0_next    = mul_ext;
                    state_next = mer_pkg::ENG_R1_RHS;
                end
            end
            mer_pkg::ENG_R1_RHS:
            begin
                t1_next    = mul_ext;
                state_next = mer_pkg::ENG_R1_CMP;
            end
            mer_pkg::ENG_R1_CMP:
            begin
                if ((t0_reg << 1) < t1_reg)
                begin
                    state_next = mer_pkg::ENG_R1_INC;
                end
                else
                begin
                    region2_next = 1'b1;
                    state_next   = mer_pkg::ENG_R2_TX;
                end
            end
            mer_pkg::ENG_R1_INC:
            begin
                t0_next    = mul_ext;
                state_next = mer_pkg::ENG_R1_DEC;
            end
            mer_pkg::ENG_R1_DEC:
            begin
                t1_next    = mul_ext;
                state_next = mer_pkg::ENG_R1_UPD;
            end
            mer_pkg::ENG_R1_UPD:
            begin
                if (dec_neg)
                begin
                    dec_next = dec_reg + (t0_reg << 2);
                end
                else
                begin
                    dec_next = dec_reg + (t0_reg << 2) - (t1_reg << 3);
                    y_next   = y_reg - AXIS_BITS'(1);
                end
                x_next     = x_reg + AXIS_BITS'(1);
                state_next = mer_pkg::ENG_EMIT;
            end
            // region 2 initial term from squares
            mer_pkg::ENG_R2_TX:
            begin
                t0_next    = mul_ext;
                state_next = mer_pkg::ENG_R2_TY;
            end
            mer_pkg::ENG_R2_TY:
            begin
                t1_next    = mul_ext;
                state_next = mer_pkg::ENG_R2_BTX;
            end
            mer_pkg::ENG_R2_BTX:
            begin
                t0_next    = mul_ext;
                state_next = mer_pkg::ENG_R2_ATY;
            end
            mer_pkg::ENG_R2_ATY:
            begin
                t1_next    = mul_ext;
                state_next = mer_pkg::ENG_R2_AB;
            end
            mer_pkg::ENG_R2_AB:
            begin
                t2_next    = mul_ext;
                dec_next   = t0_reg + (t1_reg << 2);
                state_next = mer_pkg::ENG_R2_SUB;
            end
            mer_pkg::ENG_R2_SUB:
            begin
                dec_next   = dec_reg - (t2_reg << 2);
                state_next = mer_pkg::ENG_R2_CHK;
            end
            // region 2 step
            mer_pkg::ENG_R2_CHK:
            begin
                if (y_reg == '0)
                begin
                    active_next = 1'b0;
                    state_next  = mer_pkg::ENG_IDLE;
                end
                else
                begin
                    t1_next    = mul_ext;
                    state_next = mer_pkg::ENG_R2_XT;
                end
            end
            mer_pkg::ENG_R2_XT:
            begin
                t0_next    = mul_ext;
                t2_next    = (a_sq_ext << 3) + (a_sq_ext << 2) - (t1_reg << 3);
                state_next = mer_pkg::ENG_R2_MIX;
            end
            mer_pkg::ENG_R2_MIX:
            begin
                t0_next    = (t0_reg << 3) + t2_reg;
                state_next = mer_pkg::ENG_R2_UPD;
            end
            mer_pkg::ENG_R2_UPD:
            begin
                if (dec_neg)
                begin
                    dec_next = dec_reg + t0_reg;
                    x_next   = x_reg + AXIS_BITS'(1);
                end
                else
                begin
                    dec_next = dec_reg + t2_reg;
                end
                y_next     = y_reg - AXIS_BITS'(1);
                state_next = mer_pkg::ENG_EMIT;
            end
            mer_pkg::ENG_EMIT:
            begin
                pt_ctrl.valid = 1'b1;
                pt_ctrl.done  = (y_reg == '0);
                if (pt_ready)
                begin
                    if (y_reg == '0)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = mer_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = mer_pkg::ENG_IDLE;
            end
        endcase
    end

    assign pt_org_x = org_x_reg;
    assign pt_org_y = org_y_reg;
    assign pt_x     = x_reg;
    assign pt_y     = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mer_pkg::ENG_IDLE;
            active_reg  <= 1'b0;
            region2_reg <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            a_sq_reg    <= '0;
            b_sq_reg    <= '0;
            dec_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            region2_reg <= region2_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            org_x_reg   <= org_x_next;
            org_y_reg   <= org_y_next;
            a_sq_reg    <= a_sq_next;
            b_sq_reg    <= b_sq_next;
            dec_reg     <= dec_next;
        end
    end

    // scratch products and latched semi-axes
    always_ff @(posedge clk)
    begin
        a_in_reg <= a_in_next;
        b_in_reg <= b_in_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
    end

endmodule

[hdl/mer_emit.sv]
// ----------------------------------------------------------------------------
// mer_emit
// holds one point and sends its four mirrored pixels through an output register
// ----------------------------------------------------------------------------
module mer_emit #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mer_pkg::pt_ctrl_t            pt_ctrl,
    output logic                         pt_ready,
    input  logic signed [COORD_BITS-1:0] pt_org_x,
    input  logic signed [COORD_BITS-1:0] pt_org_y,
    input  logic        [AXIS_BITS-1:0]  pt_x,
    input  logic        [AXIS_BITS-1:0]  pt_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS:0]   pixel_x,
    output logic signed [COORD_BITS:0]   pixel_y,
    output logic        [1:0]            quadrant,
    output logic                         point_last,
    output logic                         ellipse_done
);

    localparam int PIX_W = COORD_BITS + 1;
    localparam int SUM_W = ((COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS) + 2;

    logic                         pt_valid_reg, pt_valid_next;
    logic                         pt_done_reg;
    logic signed [COORD_BITS-1:0] ox_reg;
    logic signed [COORD_BITS-1:0] oy_reg;
    logic        [AXIS_BITS-1:0]  px_reg;
    logic        [AXIS_BITS-1:0]  py_reg;
    logic        [1:0]            quad_reg, quad_next;

    logic                         out_valid_reg, out_valid_next;
    logic        [PIX_W-1:0]      pixel_x_reg;
    logic        [PIX_W-1:0]      pixel_y_reg;
    logic        [1:0]            quadrant_reg;
    logic                         last_reg;
    logic                         done_reg;

    logic             load_out;
    logic             take_pt;
    logic             pos_x;
    logic             pos_y;
    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [SUM_W-1:0] mx;
    logic [SUM_W-1:0] my;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;

    assign pt_ready = !pt_valid_reg;
    assign take_pt  = pt_ctrl.valid && !pt_valid_reg;
    assign load_out = pt_valid_reg && (!out_valid_reg || !out_stall);

    // mirror signs for the current quadrant
    assign pos_x = (quad_reg == mer_pkg::QUAD_PP) || (quad_reg == mer_pkg::QUAD_PN);
    assign pos_y = (quad_reg == mer_pkg::QUAD_PP) || (quad_reg == mer_pkg::QUAD_NP);

    assign sx    = SUM_W'(ox_reg);
    assign sy    = SUM_W'(oy_reg);
    assign mx    = SUM_W'(px_reg);
    assign my    = SUM_W'(py_reg);
    assign sum_x = pos_x ? (sx + mx) : (sx - mx);
    assign sum_y = pos_y ? (sy + my) : (sy - my);

    always_comb
    begin
        pt_valid_next  = pt_valid_reg;
        quad_next      = quad_reg;
        out_valid_next = out_valid_reg;
        if (take_pt)
        begin
            pt_valid_next = 1'b1;
            quad_next     = mer_pkg::QUAD_PP;
        end
        if (load_out)
        begin
            quad_next      = quad_reg + 2'd1;
            out_valid_next = 1'b1;
            if (quad_reg == mer_pkg::QUAD_NP)
            begin
                pt_valid_next = 1'b0;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg  <= 1'b0;
            quad_reg      <= mer_pkg::QUAD_PP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pt_valid_reg  <= pt_valid_next;
            quad_reg      <= quad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_pt)
        begin
            ox_reg      <= pt_org_x;
            oy_reg      <= pt_org_y;
            px_reg      <= pt_x;
            py_reg      <= pt_y;
            pt_done_reg <= pt_ctrl.done;
        end
        if (load_out)
        begin
            pixel_x_reg  <= sum_x[PIX_W-1:0];
            pixel_y_reg  <= sum_y[PIX_W-1:0];
            quadrant_reg <= quad_reg;
            last_reg     <= (quad_reg == mer_pkg::QUAD_NP);
            done_reg     <= pt_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign quadrant     = quadrant_reg;
    assign point_last   = last_reg;
    assign ellipse_done = done_reg;

endmodule

[hdl/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// two-region midpoint ellipse walker, four mirrored pixels per point
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_stall    cmd, center_x, center_y,
//                                             semi_axis_a, semi_axis_b
//  out      from block out_valid / out_stall  pixel_x, pixel_y, quadrant,
//                                             point_last, ellipse_done
//
//  a request is taken at a clock edge with valid high and stall low
//  the engine works through each request as a sequence of states on its one
//  shared multiplier: start, region-1 step, region-2 step, a step crossing
//  regions and a step while idle; the four pixels of a point leave
//  the emitter while the engine already works on the next request
//  rst_n clears the queue, sequencer and output valid flag asynchronously
//  a two-entry queue lets the input run ahead while out_stall holds the pixels
//
`include "assert_macros.svh"

module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic        [AXIS_BITS-1:0]  semi_axis_a,
    input  logic        [AXIS_BITS-1:0]  semi_axis_b,
    // pixel channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS:0]   pixel_x,
    output logic signed [COORD_BITS:0]   pixel_y,
    output logic        [1:0]            quadrant,
    output logic                         point_last,
    output logic                         ellipse_done
);

    // front to engine queue head
    logic                         q_valid;
    logic                         q_pop;
    mer_pkg::req_kind_t           q_kind;
    logic signed [COORD_BITS-1:0] q_cx;
    logic signed [COORD_BITS-1:0] q_cy;
    logic        [AXIS_BITS-1:0]  q_a;
    logic        [AXIS_BITS-1:0]  q_b;

    // engine to emitter point hand-off
    mer_pkg::pt_ctrl_t            pt_ctrl;
    logic                         pt_ready;
    logic signed [COORD_BITS-1:0] pt_org_x;
    logic signed [COORD_BITS-1:0] pt_org_y;
    logic        [AXIS_BITS-1:0]  pt_x;
    logic        [AXIS_BITS-1:0]  pt_y;

    // front: accepts and classifies requests into a short queue
    mer_front #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .center_x    (center_x),
        .center_y    (center_y),
        .semi_axis_a (semi_axis_a),
        .semi_axis_b (semi_axis_b),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_kind      (q_kind),
        .q_cx        (q_cx),
        .q_cy        (q_cy),
        .q_a         (q_a),
        .q_b         (q_b)
    );

    // engine: decision term, region switch and point update
    mer_engine #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_kind   (q_kind),
        .q_cx     (q_cx),
        .q_cy     (q_cy),
        .q_a      (q_a),
        .q_b      (q_b),
        .pt_ctrl  (pt_ctrl),
        .pt_ready (pt_ready),
        .pt_org_x (pt_org_x),
        .pt_org_y (pt_org_y),
        .pt_x     (pt_x),
        .pt_y     (pt_y)
    );

    // emitter: four mirrored pixels per point, registered output
    mer_emit #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .pt_ctrl      (pt_ctrl),
        .pt_ready     (pt_ready),
        .pt_org_x     (pt_org_x),
        .pt_org_y     (pt_org_y),
        .pt_x         (pt_x),
        .pt_y         (pt_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .quadrant     (quadrant),
        .point_last   (point_last),
        .ellipse_done (ellipse_done)
    );

    // the last pixel of a point is always the (-x,+y) mirror
    `ASSERT_IMPLY(a_last_is_np, clk, rst_n, out_valid && point_last, quadrant == mer_pkg::QUAD_NP)

    // the four pixels of a point leave without gaps
    `ASSERT_NEXT(a_point_burst, clk, rst_n, out_valid && !out_stall && !point_last, out_valid)

    // the done flag is the same on all pixels of one point
    `ASSERT_NEXT(a_done_steady, clk, rst_n, out_valid && !out_stall && !point_last, $stable(ellipse_done))

endmodule
